>>> hw/rtl/bbsre_pkg.sv
// Shared constants and types for the byte buffer shift/rotate engine.
package bbsre_pkg;

    localparam int MAX_BYTES_DEF = 256;
    localparam int LEN_W         = 9;
    localparam int AMT_W         = 16;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 8;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [3:0] {
        OP_WRITE = 4'd0,
        OP_READ  = 4'd1,
        OP_SHL   = 4'd2,
        OP_SHR   = 4'd3,
        OP_ROTL  = 4'd4,
        OP_ROTR  = 4'd5,
        OP_ALL   = 4'd6,
        OP_ANY   = 4'd7,
        OP_NONE  = 4'd8
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH     = 2'd0,
        CFG_ENDIAN_BIG = 2'd1,
        CFG_ORDER_IND  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] rem;
    } t_mod_res;

endpackage

>>> hw/rtl/bbsre_mod_unit.sv
// Bit-serial remainder unit: dividend modulo divisor, one quotient bit per cycle.
module bbsre_mod_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [bbsre_pkg::AMT_W-1:0]         i_dividend,
    input  logic [bbsre_pkg::LEN_W-1:0]         i_divisor,
    output bbsre_pkg::t_mod_res                 o_res
);

    localparam int AW = bbsre_pkg::AMT_W;
    localparam int LW = bbsre_pkg::LEN_W;
    localparam int BW = $clog2(AW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [BW-1:0] r_bit, n_bit;
    logic [AW-1:0] r_dvd, n_dvd;
    logic [LW-1:0] r_dvs, n_dvs;
    logic [LW-1:0] r_rem, n_rem;

    logic [LW:0]   w_sh;
    logic          w_ge;
    logic [LW-1:0] w_next;

    always_comb begin
        w_sh   = {r_rem, r_dvd[AW-1]};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_next = w_ge ? LW'(w_sh - {1'b0, r_dvs}) : w_sh[LW-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_bit  = r_bit;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_bit  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_next;
            n_dvd = {r_dvd[AW-2:0], 1'b0};
            n_bit = r_bit + BW'(1);
            if (r_bit == BW'(AW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

endmodule

>>> hw/rtl/byte_buffer_shift_rotate_engine_unit.sv
// Byte buffer shift/rotate engine top level: sequencer, byte store and scratch memory.
// Each request yields one result. All work goes through a byte store with a single
// registered read port, one byte per cycle. Write and out-of-range or no-op requests go
// straight to the result; a read waits for the store read; a shift makes one pass over
// the used length; a rotate starts and runs the 16-step serial modulo, makes a copy pass
// into scratch, a drain step and then a write-back pass, or ends when the reduced amount
// is zero; a range test reads each tested byte, then drains. A stalled result register
// holds back the end of any request.
// A new request is taken once the previous one has finished, even while its result
// still waits in the output register. The store holds no defined data until written.
module byte_buffer_shift_rotate_engine_unit #(
    parameter int MAX_BYTES = bbsre_pkg::MAX_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbsre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bbsre_pkg::LEN_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [3:0]                          i_op,
    input  logic [bbsre_pkg::IDX_W-1:0]         i_index,
    input  logic [bbsre_pkg::IDX_W-1:0]         i_last_index,
    input  logic                                i_to_end,
    input  logic [bbsre_pkg::AMT_W-1:0]         i_amount,
    input  logic [bbsre_pkg::BYTE_W-1:0]        i_byte_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bbsre_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                                o_flag
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LW = bbsre_pkg::LEN_W;
    localparam int MW = bbsre_pkg::AMT_W;
    localparam int DW = bbsre_pkg::BYTE_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_MOD    = 9'b000000100,
        S_COPY   = 9'b000001000,
        S_CDRAIN = 9'b000010000,
        S_MOVE   = 9'b000100000,
        S_TEST   = 9'b001000000,
        S_TDRAIN = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic          we_store;
        logic          we_scr;
        logic          fill;
        logic          from_scr;
        logic [LW-1:0] dst;
    } t_wr;

    // configuration
    logic [LW-1:0] r_buffer_length;
    logic          r_endian_big;
    logic          r_order_ind;

    t_state        r_state, n_state;
    logic [3:0]    r_op, n_op;
    logic [DW-1:0] r_val, n_val;
    logic [LW-1:0] r_len, n_len;
    logic [MW-1:0] r_amt, n_amt;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_last, n_last;
    logic          r_bigdep, n_bigdep;
    logic          r_toward_low, n_toward_low;
    logic          r_rot, n_rot;
    logic          r_hit, n_hit;
    logic          r_all, n_all;
    logic          r_tv, n_tv;
    logic [DW-1:0] r_rd, n_rd;
    logic          r_flag, n_flag;
    logic          r_out_vld, n_out_vld;
    logic [DW-1:0] r_out_byte, n_out_byte;
    logic          r_out_flag, n_out_flag;
    t_wr           r_wr, n_wr;
    logic          r_mod_start, n_mod_start;

    logic [DW-1:0] r_store [MAX_BYTES];
    logic [DW-1:0] r_scr   [MAX_BYTES];
    logic [DW-1:0] r_store_q;
    logic [DW-1:0] r_scr_q;

    bbsre_pkg::t_mod_res w_mod;

    logic [LW-1:0] w_len;
    logic          w_bigdep;
    logic          w_le_dep;
    logic [LW-1:0] w_in_idx;
    logic [LW-1:0] w_in_phys;
    logic          w_in_range;
    logic [LW-1:0] w_tlast;
    logic [LW-1:0] w_k;
    logic [MW:0]   w_sum;
    logic [LW:0]   w_rsum;
    logic [LW-1:0] w_src;
    logic          w_fill;
    logic [LW-1:0] w_tpos;
    logic [LW-1:0] w_store_rpos;
    logic [DW-1:0] w_wdata;
    logic          w_eq;
    logic          w_hit_f;
    logic          w_all_f;

    assign w_len      = (32'(r_buffer_length) > MAX_BYTES) ? LW'(MAX_BYTES) : r_buffer_length;
    assign w_bigdep   = r_endian_big & ~r_order_ind;
    assign w_le_dep   = ~r_endian_big & ~r_order_ind;
    assign w_in_idx   = {1'b0, i_index};
    assign w_in_phys  = w_bigdep ? (w_len - LW'(1) - w_in_idx) : w_in_idx;
    assign w_in_range = w_in_idx < w_len;
    assign w_tlast    = i_to_end ? (w_len - LW'(1)) : {1'b0, i_last_index};

    // destination position of this step; walk direction keeps the move in place
    assign w_k    = r_toward_low ? r_cnt : (r_len - LW'(1) - r_cnt);
    assign w_sum  = (MW+1)'(w_k) + (MW+1)'(r_amt);
    assign w_rsum = (LW+1)'(w_k) + (LW+1)'(r_amt[LW-1:0]);

    always_comb begin
        w_fill = 1'b0;
        if (r_rot) begin
            if (r_toward_low) begin
                w_src = (w_rsum >= (LW+1)'(r_len)) ? LW'(w_rsum - (LW+1)'(r_len))
                                                   : w_rsum[LW-1:0];
            end else begin
                w_src = (w_k >= r_amt[LW-1:0]) ? (w_k - r_amt[LW-1:0])
                                               : (w_k + r_len - r_amt[LW-1:0]);
            end
        end else if (r_toward_low) begin
            w_fill = w_sum >= (MW+1)'(r_len);
            w_src  = w_sum[LW-1:0];
        end else begin
            w_fill = MW'(w_k) < r_amt;
            w_src  = w_k - r_amt[LW-1:0];
        end
    end

    assign w_tpos = r_bigdep ? (r_len - LW'(1) - r_cnt) : r_cnt;

    always_comb begin
        case (r_state)
            S_IDLE:  w_store_rpos = w_in_phys;
            S_TEST:  w_store_rpos = w_tpos;
            S_COPY:  w_store_rpos = r_cnt;
            default: w_store_rpos = w_src;
        endcase
    end

    assign w_wdata = r_wr.fill ? r_val : (r_wr.from_scr ? r_scr_q : r_store_q);

    assign w_eq    = r_store_q == r_val;
    assign w_hit_f = r_hit | (r_tv & w_eq);
    assign w_all_f = r_all & ~(r_tv & ~w_eq);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_len        = r_len;
        n_amt        = r_amt;
        n_cnt        = r_cnt;
        n_last       = r_last;
        n_bigdep     = r_bigdep;
        n_toward_low = r_toward_low;
        n_rot        = r_rot;
        n_hit        = w_hit_f;
        n_all        = w_all_f;
        n_tv         = 1'b0;
        n_rd         = r_rd;
        n_flag       = r_flag;
        n_out_vld    = r_out_vld;
        n_out_byte   = r_out_byte;
        n_out_flag   = r_out_flag;
        n_wr         = '0;
        n_mod_start  = 1'b0;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_op;
                    n_val        = i_byte_value;
                    n_len        = w_len;
                    n_amt        = i_amount;
                    n_bigdep     = w_bigdep;
                    n_rd         = '0;
                    n_flag       = 1'b0;
                    n_cnt        = '0;
                    n_rot        = 1'b0;
                    n_toward_low = (i_op inside {bbsre_pkg::OP_SHL, bbsre_pkg::OP_ROTL})
                                   ? ~w_le_dep : w_le_dep;
                    n_state      = S_DONE;
                    case (i_op)
                        bbsre_pkg::OP_WRITE: begin
                            if (w_in_range) begin
                                n_flag        = 1'b1;
                                n_wr.we_store = 1'b1;
                                n_wr.fill     = 1'b1;
                                n_wr.dst      = w_in_phys;
                            end
                        end
                        bbsre_pkg::OP_READ: begin
                            // store read of the mapped position is issued this edge
                            if (w_in_range) begin
                                n_state = S_READ;
                            end
                        end
                        bbsre_pkg::OP_SHL, bbsre_pkg::OP_SHR: begin
                            if (w_len != '0 && i_amount != '0) begin
                                n_state = S_MOVE;
                            end
                        end
                        bbsre_pkg::OP_ROTL, bbsre_pkg::OP_ROTR: begin
                            if (w_len != '0) begin
                                n_rot       = 1'b1;
                                n_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                        bbsre_pkg::OP_ALL, bbsre_pkg::OP_ANY, bbsre_pkg::OP_NONE: begin
                            if (w_len != '0 && w_in_idx <= w_tlast && w_tlast < w_len) begin
                                n_cnt   = w_in_idx;
                                n_last  = w_tlast;
                                n_hit   = 1'b0;
                                n_all   = 1'b1;
                                n_state = S_TEST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_rd    = r_store_q;
                n_flag  = 1'b1;
                n_state = S_DONE;
            end
            S_MOD: begin
                if (w_mod.done) begin
                    if (w_mod.rem == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_amt   = MW'(w_mod.rem);
                        n_cnt   = '0;
                        n_state = S_COPY;
                    end
                end
            end
            S_COPY: begin
                n_wr.we_scr = 1'b1;
                n_wr.dst    = r_cnt;
                if (r_cnt == r_len - LW'(1)) begin
                    n_cnt   = '0;
                    n_state = S_CDRAIN;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            S_CDRAIN: begin
                // last scratch write lands before the first scratch read
                n_state = S_MOVE;
            end
            S_MOVE: begin
                n_wr.we_store = 1'b1;
                n_wr.dst      = w_k;
                n_wr.fill     = ~r_rot & w_fill;
                n_wr.from_scr = r_rot;
                if (r_cnt == r_len - LW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            S_TEST: begin
                n_tv = 1'b1;
                if (r_cnt == r_last) begin
                    n_state = S_TDRAIN;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            S_TDRAIN: begin
                case (r_op)
                    bbsre_pkg::OP_ALL: n_flag = w_all_f;
                    bbsre_pkg::OP_ANY: n_flag = w_hit_f;
                    default:           n_flag = ~w_hit_f;
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = r_rd;
                    n_out_flag = r_flag;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= '0;
            r_endian_big    <= 1'b0;
            r_order_ind     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bbsre_pkg::CFG_LENGTH:     r_buffer_length <= i_cfg_wdata;
                bbsre_pkg::CFG_ENDIAN_BIG: r_endian_big    <= i_cfg_wdata[0];
                bbsre_pkg::CFG_ORDER_IND:  r_order_ind     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_vld   <= 1'b0;
            r_tv        <= 1'b0;
            r_wr        <= '0;
            r_mod_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_vld   <= n_out_vld;
            r_tv        <= n_tv;
            r_wr        <= n_wr;
            r_mod_start <= n_mod_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_len        <= n_len;
        r_amt        <= n_amt;
        r_cnt        <= n_cnt;
        r_last       <= n_last;
        r_bigdep     <= n_bigdep;
        r_toward_low <= n_toward_low;
        r_rot        <= n_rot;
        r_hit        <= n_hit;
        r_all        <= n_all;
        r_rd         <= n_rd;
        r_flag       <= n_flag;
        r_out_byte   <= n_out_byte;
        r_out_flag   <= n_out_flag;
    end

    always_ff @(posedge i_clk) begin
        if (r_wr.we_store) begin
            r_store[AW'(r_wr.dst)] <= w_wdata;
        end
        r_store_q <= r_store[AW'(w_store_rpos)];
    end

    always_ff @(posedge i_clk) begin
        if (r_wr.we_scr) begin
            r_scr[AW'(r_wr.dst)] <= w_wdata;
        end
        r_scr_q <= r_scr[AW'(w_src)];
    end

    bbsre_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_amt),
        .i_divisor  (r_len),
        .o_res      (w_mod)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_read_byte = r_out_byte;
    assign o_flag      = r_out_flag;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the byte buffer shift/rotate engine.
module tb_top;

    localparam int          DEPTH        = bbsre_pkg::MAX_BYTES_DEF;
    localparam int          PW           = $clog2(DEPTH);
    localparam int          IW           = bbsre_pkg::IDX_W;
    localparam int          AMW          = bbsre_pkg::AMT_W;
    localparam int          BYW          = bbsre_pkg::BYTE_W;
    localparam int          LNW          = bbsre_pkg::LEN_W;
    localparam int          CIW          = bbsre_pkg::CFG_IDX_W;
    localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [3:0]     op;
        logic [IW-1:0]  index;
        logic [IW-1:0]  last_index;
        logic           to_end;
        logic [AMW-1:0] amount;
        logic [BYW-1:0] byte_value;
    } t_buf_req;

    typedef struct packed {
        logic [BYW-1:0] read_byte;
        logic           flag;
    } t_buf_rsp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CIW-1:0]        i_cfg_idx;
    logic [LNW-1:0]        i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [3:0]            i_op;
    logic [IW-1:0]         i_index;
    logic [IW-1:0]         i_last_index;
    logic                  i_to_end;
    logic [AMW-1:0]        i_amount;
    logic [BYW-1:0]        i_byte_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BYW-1:0]        o_read_byte;
    logic                  o_flag;

    // shadow copy of the store and the registers
    logic [BYW-1:0]        shadow_bytes [DEPTH];
    logic [LNW-1:0]        shadow_len;
    logic                  shadow_big;
    logic                  shadow_order_ind;

    t_buf_rsp              awaited_rsp [$];
    int unsigned           mismatch_count = 0;
    int unsigned           burst_left;
    int unsigned           hold_seq = 0;

    byte_buffer_shift_rotate_engine_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_last_index (i_last_index),
        .i_to_end     (i_to_end),
        .i_amount     (i_amount),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_byte  (o_read_byte),
        .o_flag       (o_flag)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned used_len();
        return (32'(shadow_len) > DEPTH) ? DEPTH : 32'(shadow_len);
    endfunction

    function automatic int unsigned phys_of(int unsigned i, int unsigned len);
        return (shadow_big && !shadow_order_ind) ? len - 1 - i : i;
    endfunction

    function automatic void move_shadow(int unsigned len, int unsigned amt, bit to_low,
                                        bit rotate, logic [BYW-1:0] fill);
        logic [BYW-1:0] snap [DEPTH];
        int unsigned    s;
        int unsigned    k;
        s = amt;
        if (len == 0) return;
        if (rotate) s = s % len;
        if (s == 0) return;
        snap = shadow_bytes;
        for (k = 0; k < len; k++) begin
            if (rotate)
                shadow_bytes[PW'(k)] = to_low ? snap[PW'((k + s) % len)]
                                              : snap[PW'((k + len - s) % len)];
            else if (to_low)
                shadow_bytes[PW'(k)] = (s < len - k) ? snap[PW'(k + s)] : fill;
            else
                shadow_bytes[PW'(k)] = (k >= s) ? snap[PW'(k - s)] : fill;
        end
    endfunction

    function automatic logic range_flag(t_buf_req r, int unsigned len);
        int unsigned first;
        int unsigned last;
        int unsigned i;
        bit          hit_any;
        bit          all_eq;
        hit_any = 1'b0;
        all_eq  = 1'b1;
        if (len == 0) return 1'b0;
        first = 32'(r.index);
        last  = r.to_end ? len - 1 : 32'(r.last_index);
        if (first > last || last >= len) return 1'b0;
        for (i = first; i <= last; i++) begin
            if (shadow_bytes[PW'(phys_of(i, len))] == r.byte_value) hit_any = 1'b1;
            else all_eq = 1'b0;
        end
        case (r.op)
            bbsre_pkg::OP_ALL: return all_eq;
            bbsre_pkg::OP_ANY: return hit_any;
            default:           return !hit_any;
        endcase
    endfunction

    // updates the shadow store and returns the result the request must give
    function automatic t_buf_rsp apply_buffer_op(t_buf_req r);
        t_buf_rsp    res;
        int unsigned len;
        bit          le_dep;
        res    = '0;
        len    = used_len();
        le_dep = !shadow_big && !shadow_order_ind;
        case (r.op)
            bbsre_pkg::OP_WRITE: begin
                if (32'(r.index) < len) begin
                    shadow_bytes[PW'(phys_of(32'(r.index), len))] = r.byte_value;
                    res.flag = 1'b1;
                end
            end
            bbsre_pkg::OP_READ: begin
                if (32'(r.index) < len) begin
                    res.read_byte = shadow_bytes[PW'(phys_of(32'(r.index), len))];
                    res.flag      = 1'b1;
                end
            end
            bbsre_pkg::OP_SHL:  move_shadow(len, 32'(r.amount), !le_dep, 1'b0, r.byte_value);
            bbsre_pkg::OP_SHR:  move_shadow(len, 32'(r.amount), le_dep, 1'b0, r.byte_value);
            bbsre_pkg::OP_ROTL: move_shadow(len, 32'(r.amount), !le_dep, 1'b1, '0);
            bbsre_pkg::OP_ROTR: move_shadow(len, 32'(r.amount), le_dep, 1'b1, '0);
            bbsre_pkg::OP_ALL, bbsre_pkg::OP_ANY, bbsre_pkg::OP_NONE:
                res.flag = range_flag(r, len);
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_buf_req mk_req(logic [3:0] op, int unsigned index, int unsigned last,
                                        int unsigned to_end, int unsigned amount,
                                        int unsigned value);
        t_buf_req r;
        r.op         = op;
        r.index      = IW'(index);
        r.last_index = IW'(last);
        r.to_end     = (to_end != 0);
        r.amount     = AMW'(amount);
        r.byte_value = BYW'(value);
        return r;
    endfunction

    function automatic t_buf_req rand_req();
        t_buf_req    r;
        int unsigned len;
        int unsigned sel;
        len = used_len();
        sel = $urandom_range(0, 99);
        if (sel < 18)      r.op = bbsre_pkg::OP_WRITE;
        else if (sel < 36) r.op = bbsre_pkg::OP_READ;
        else if (sel < 44) r.op = bbsre_pkg::OP_SHL;
        else if (sel < 52) r.op = bbsre_pkg::OP_SHR;
        else if (sel < 60) r.op = bbsre_pkg::OP_ROTL;
        else if (sel < 68) r.op = bbsre_pkg::OP_ROTR;
        else if (sel < 77) r.op = bbsre_pkg::OP_ALL;
        else if (sel < 86) r.op = bbsre_pkg::OP_ANY;
        else if (sel < 95) r.op = bbsre_pkg::OP_NONE;
        else               r.op = 4'($urandom_range(32'(OP_UNUSED_LO), 32'(OP_UNUSED_HI)));
        if (len != 0 && $urandom_range(0, 9) < 8) r.index = IW'($urandom_range(0, len - 1));
        else r.index = IW'($urandom_range(0, 255));
        if (len != 0 && 32'(r.index) < len && $urandom_range(0, 4) != 0)
            r.last_index = IW'($urandom_range(32'(r.index), len - 1));
        else
            r.last_index = IW'($urandom_range(0, 255));
        r.to_end = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0:       r.amount = '0;
            1:       r.amount = AMW'($urandom_range(1, 3));
            2:       r.amount = AMW'($urandom_range(1, len + 1));
            3:       r.amount = AMW'(len);
            4:       r.amount = AMW'((len != 0) ? len - 1 : 0);
            default: r.amount = AMW'($urandom_range(0, 65535));
        endcase
        // bias compared values toward bytes that are actually present
        case ($urandom_range(0, 3))
            0:       r.byte_value = 8'h00;
            1:       r.byte_value = 8'hFF;
            2:       r.byte_value = (len != 0) ? shadow_bytes[PW'($urandom_range(0, len - 1))]
                                               : 8'h00;
            default: r.byte_value = BYW'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic push_request(input t_buf_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        i_op         = r.op;
        i_index      = r.index;
        i_last_index = r.last_index;
        i_to_end     = r.to_end;
        i_amount     = r.amount;
        i_byte_value = r.byte_value;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        awaited_rsp.push_back(apply_buffer_op(r));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input bbsre_pkg::t_cfg_idx idx, input logic [LNW-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            bbsre_pkg::CFG_LENGTH:     shadow_len       = value;
            bbsre_pkg::CFG_ENDIAN_BIG: shadow_big       = value[0];
            bbsre_pkg::CFG_ORDER_IND:  shadow_order_ind = value[0];
            default: ;
        endcase
    endtask

    // every used byte gets defined content before anything reads it
    task automatic seed_store();
        int unsigned len;
        int unsigned i;
        len = used_len();
        if (len == 0) return;
        if (len <= 32) begin
            for (i = 0; i < len; i++)
                push_request(mk_req(bbsre_pkg::OP_WRITE, i, 0, 0, 0, $urandom_range(0, 255)));
        end else begin
            push_request(mk_req(bbsre_pkg::OP_SHL, 0, 0, 0, len + $urandom_range(0, 1000),
                                $urandom_range(0, 255)));
            repeat (16)
                push_request(mk_req(bbsre_pkg::OP_WRITE, $urandom_range(0, len - 1), 0, 0, 0,
                                    $urandom_range(0, 255)));
        end
    endtask

    task automatic enter_phase(input int unsigned len, input bit big, input bit order_ind);
        wait_results_drained();
        write_cfg(bbsre_pkg::CFG_LENGTH, LNW'(len));
        write_cfg(bbsre_pkg::CFG_ENDIAN_BIG, LNW'(big));
        write_cfg(bbsre_pkg::CFG_ORDER_IND, LNW'(order_ind));
        seed_store();
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) push_request(rand_req());
    endtask

    // reset length is zero: everything is a no-op
    task automatic test_zero_length();
        push_request(mk_req(bbsre_pkg::OP_WRITE, 0, 0, 0, 0, 'h5A));
        push_request(mk_req(bbsre_pkg::OP_READ, 0, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_READ, 255, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_SHL, 0, 0, 0, 1, 'hFF));
        push_request(mk_req(bbsre_pkg::OP_SHR, 0, 0, 0, 65535, 'h01));
        push_request(mk_req(bbsre_pkg::OP_ROTL, 0, 0, 0, 5, 0));
        push_request(mk_req(bbsre_pkg::OP_ALL, 0, 0, 1, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_NONE, 0, 0, 0, 0, 'h33));
        push_request(mk_req(OP_UNUSED_LO, 0, 0, 0, 0, 0));
    endtask

    task automatic test_directed();
        enter_phase(8, 1'b0, 1'b0);
        push_request(mk_req(bbsre_pkg::OP_WRITE, 0, 0, 0, 0, 'h00));
        push_request(mk_req(bbsre_pkg::OP_WRITE, 7, 0, 0, 0, 'hFF));
        push_request(mk_req(bbsre_pkg::OP_WRITE, 8, 0, 0, 0, 'h11));
        push_request(mk_req(bbsre_pkg::OP_WRITE, 255, 255, 1, 65535, 'h22));
        push_request(mk_req(bbsre_pkg::OP_READ, 0, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_READ, 7, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_READ, 8, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_READ, 255, 0, 0, 0, 0));
        push_request(mk_req(bbsre_pkg::OP_SHL, 0, 0, 0, 0, 'hEE));
        push_request(mk_req(bbsre_pkg::OP_SHL, 0, 0, 0, 1, 'hA5));
        push_request(mk_req(bbsre_pkg::OP_SHR, 0, 0, 0, 3, 'h3C));
        push_request(mk_req(bbsre_pkg::OP_SHL, 0, 0, 0, 8, 'h77));
        push_request(mk_req(bbsre_pkg::OP_WRITE, 3, 0, 0, 0, 'h01));
        push_request(mk_req(bbsre_pkg::OP_ALL, 0, 7, 0, 0, 'h77));
        push_request(mk_req(bbsre_pkg::OP_ANY, 2, 0, 1, 0, 'h01));
        push_request(mk_req(bbsre_pkg::OP_NONE, 5, 2, 0, 0, 'h42));
        push_request(mk_req(bbsre_pkg::OP_ALL, 0, 8, 0, 0, 'h77));
        push_request(mk_req(bbsre_pkg::OP_NONE, 0, 2, 0, 0, 'h01));
        push_request(mk_req(bbsre_pkg::OP_SHR, 0, 0, 0, 65535, 'h5A));
        push_request(mk_req(bbsre_pkg::OP_WRITE, 1, 0, 0, 0, 'hC3));
        push_request(mk_req(bbsre_pkg::OP_ROTL, 0, 0, 0, 65535, 0));
        push_request(mk_req(bbsre_pkg::OP_ROTR, 0, 0, 0, 8, 0));
        push_request(mk_req(bbsre_pkg::OP_ROTR, 0, 0, 0, 3, 0));
        push_request(mk_req(bbsre_pkg::OP_ROTL, 0, 0, 0, 1, 0));
        push_request(mk_req(OP_UNUSED_HI, 255, 255, 1, 65535, 'hFF));
    endtask

    // long receiver hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        enter_phase(12, 1'b1, 1'b0);
        hold_seq++;
        burst_left = 40;
        run_random(30);
        wait_results_drained();
        run_random(20);
    endtask

    task automatic test_random_phases();
        int unsigned big_lens [5];
        int unsigned ph;
        big_lens = '{128, 255, 256, 300, 511};
        enter_phase(0, 1'b1, 1'b0);
        run_random(30);
        for (ph = 0; ph < 16; ph++) begin
            enter_phase((ph < 2) ? ph + 1 : $urandom_range(1, 16), ph[1], ph[0]);
            run_random(55);
        end
        for (ph = 0; ph < 4; ph++) begin
            enter_phase($urandom_range(17, 96), ph[0], ph[1]);
            run_random(60);
        end
        for (ph = 0; ph < 5; ph++) begin
            enter_phase(big_lens[ph], ph[1], ph[0]);
            run_random(40);
        end
    endtask

    // receiver stall pattern, switching between styles
    initial begin : rx_stall
        int unsigned mode;
        int unsigned mode_left;
        int unsigned k;
        int unsigned tick;
        int unsigned hold_seen;
        mode        = 0;
        mode_left   = 0;
        tick        = 0;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen   = hold_seq;
                i_out_stall = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((tick % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_buf_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_rsp.size() == 0) begin
                $error("result with no request pending: read_byte %0h flag %0d",
                       o_read_byte, o_flag);
                mismatch_count++;
            end else begin
                want = awaited_rsp.pop_front();
                if (o_read_byte !== want.read_byte) begin
                    $error("read_byte mismatch: expected %0h, actual %0h",
                           want.read_byte, o_read_byte);
                    mismatch_count++;
                end
                if (o_flag !== want.flag) begin
                    $error("flag mismatch: expected %0d, actual %0d", want.flag, o_flag);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : main_seq
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = bbsre_pkg::CFG_LENGTH;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_op             = bbsre_pkg::OP_WRITE;
        i_index          = '0;
        i_last_index     = '0;
        i_to_end         = 1'b0;
        i_amount         = '0;
        i_byte_value     = '0;
        shadow_len       = '0;
        shadow_big       = 1'b0;
        shadow_order_ind = 1'b0;
        burst_left       = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_zero_length();
        test_directed();
        test_backpressure();
        test_random_phases();
        wait_results_drained();
        repeat (600) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
